[hw/rtl/p3s_pkg.sv]
// ----------------------------------------------------------------------------
// p3s_pkg
// shared widths, constants, state codes and the saturating sum helper of
// the power-of-three series block
// ----------------------------------------------------------------------------
package p3s_pkg;

   // fixed-point format
   localparam int FRAC_BITS  = 28;
   localparam int X_W        = 32;
   localparam int U_W        = 32;
   localparam int MAG_W      = 61;
   localparam int PROD_W     = MAG_W + U_W;
   localparam int DIV_W      = 62;
   localparam int DIV_STEPS  = DIV_W / 2;
   localparam int DCNT_W     = $clog2(DIV_STEPS);
   localparam int SUM_W      = 48;
   localparam int CNT_W      = 6;
   localparam int TOL_W      = 29;
   localparam int USED_OUT_W = 7;
   localparam int USED_CAP   = 127;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = TOL_W;
   localparam logic [CSR_IDX_W-1:0] CSR_TERM_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE  = 1'b1;
   localparam logic [TOL_W-1:0]     TOL_RESET      = 29'd26844;

   // ln3 rounded to FRAC_BITS fraction bits, taken from a 41-bit fraction
   localparam logic [63:0]    LN3_Q41  = 64'd2415873971616;
   localparam logic [63:0]    LN3_WIDE = ((LN3_Q41 >> (40 - FRAC_BITS)) + 64'd1) >> 1;
   localparam logic [U_W-1:0] LN3_Q    = LN3_WIDE[U_W-1:0];

   localparam logic [MAG_W-1:0]  ONE_Q       = MAG_W'(1) << FRAC_BITS;
   localparam logic [MAG_W-1:0]  TERM_LIMIT  = MAG_W'(1) << 60;
   localparam logic [PROD_W:0]   RND_HALF    = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

   typedef enum logic [9:0] {
      ST_IDLE     = 10'b00_0000_0001,
      ST_X_MUL    = 10'b00_0000_0010,
      ST_X_RND    = 10'b00_0000_0100,
      ST_ACC      = 10'b00_0000_1000,
      ST_MUL_LO   = 10'b00_0001_0000,
      ST_MUL_HI   = 10'b00_0010_0000,
      ST_RND      = 10'b00_0100_0000,
      ST_DIV_INIT = 10'b00_1000_0000,
      ST_DIV      = 10'b01_0000_0000,
      ST_FIN      = 10'b10_0000_0000
   } state_type;

   // acc plus or minus a term magnitude, clamped to the signed sum range
   function automatic logic signed [SUM_W-1:0] sat_add(
      input logic signed [SUM_W-1:0] acc,
      input logic [MAG_W-1:0]        mag,
      input logic                    neg
   );
      logic signed [MAG_W+1:0] a_ext;
      logic signed [MAG_W+1:0] m_ext;
      logic signed [MAG_W+1:0] wide;
      logic signed [MAG_W+1:0] hi_lim;
      logic signed [MAG_W+1:0] lo_lim;
      a_ext  = {{(MAG_W + 2 - SUM_W){acc[SUM_W-1]}}, acc};
      m_ext  = {2'b00, mag};
      wide   = neg ? (a_ext - m_ext) : (a_ext + m_ext);
      hi_lim = {{(MAG_W + 3 - SUM_W){1'b0}}, {(SUM_W - 1){1'b1}}};
      lo_lim = {{(MAG_W + 3 - SUM_W){1'b1}}, {(SUM_W - 1){1'b0}}};
      if (wide > hi_lim) begin
         sat_add = hi_lim[SUM_W-1:0];
      end else if (wide < lo_lim) begin
         sat_add = lo_lim[SUM_W-1:0];
      end else begin
         sat_add = wide[SUM_W-1:0];
      end
   endfunction

endpackage

[hw/rtl/power_of_three_series.sv]
// ----------------------------------------------------------------------------
// power_of_three_series
// Taylor-series approximation of 3^x in fixed point. One signed Q3.28
// argument per request transaction gives one response transaction with two
// saturated Q19.28 sums: one over terms 0..term_count, one that stops after
// the first term whose magnitude is at most the tolerance (or after
// MAX_TERMS terms, flagged by limit_hit). Each term is made from the one
// before by one multiply by ln3*x and one division by the term index, all
// on a single 32x32 multiplier and a two-bit-per-cycle divider under a
// small sequencer. Each term takes two multiplier passes, a rounding
// step, a bias step, the divider steps and an accumulate step. No new
// request is taken while a transaction is in work; a finished response
// waits in its own register, so the next request may be accepted while
// it is still stalled.
// ----------------------------------------------------------------------------
module power_of_three_series
   import p3s_pkg::*;
#(
   parameter int MAX_TERMS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   // configuration
   input  logic                    csr_write,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [X_W-1:0]   req_x_value,
   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [SUM_W-1:0] rsp_sum_fixed_terms,
   output logic signed [SUM_W-1:0] rsp_sum_to_tolerance,
   output logic [USED_OUT_W-1:0]   rsp_terms_used,
   output logic                    rsp_limit_hit
);

   // last term index visited, width of the term index and of the term tally
   localparam int LAST    = (MAX_TERMS - 1 > 63) ? (MAX_TERMS - 1) : 63;
   localparam int K_W     = $clog2(LAST + 1);
   localparam int USED_W  = $clog2(MAX_TERMS + 1);
   localparam int USED_XW = (USED_W > USED_OUT_W) ? USED_W : USED_OUT_W;
   localparam int LIM_OUT = (MAX_TERMS > USED_CAP) ? USED_CAP : MAX_TERMS;

   // sequencer and configuration
   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       tc_ff, tc_in;
   logic [TOL_W-1:0]       tol_ff, tol_in;

   // working registers of one transaction
   logic [U_W-1:0]         xmag_ff, xmag_in;
   logic                   neg_u_ff, neg_u_in;
   logic [U_W-1:0]         u_ff, u_in;
   logic [MAG_W-1:0]       mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic [K_W-1:0]         k_ff, k_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [DIV_W-1:0]       div_ff, div_in;
   logic [K_W-1:0]         rem_ff, rem_in;
   logic [DCNT_W-1:0]      dcnt_ff, dcnt_in;
   logic signed [SUM_W-1:0] fixed_ff, fixed_in;
   logic signed [SUM_W-1:0] tsum_ff, tsum_in;
   logic [USED_W-1:0]      used_ff, used_in;
   logic                   active_ff, active_in;

   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_W-1:0] rsp_fixed_ff, rsp_fixed_in;
   logic signed [SUM_W-1:0] rsp_tsum_ff, rsp_tsum_in;
   logic [USED_OUT_W-1:0]   rsp_used_ff, rsp_used_in;
   logic                    rsp_limit_ff, rsp_limit_in;

   // shared datapath signals
   logic [U_W-1:0]         mul_a, mul_b;
   logic [2*U_W-1:0]       mul_p;
   logic [PROD_W:0]        rnd_sum, rnd_full;
   logic [MAG_W-1:0]       term_p;
   logic [K_W:0]           dvs, r1_raw, r1, r2_raw, r2;
   logic                   q1, q2;
   logic [DIV_W-1:0]       div_step;
   logic [USED_XW-1:0]     used_x;
   logic [USED_OUT_W-1:0]  used_sat;
   logic                   req_take, rsp_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // the one multiplier: argument times ln3, or a term half times u
   always_comb begin
      mul_a = mag_ff[U_W-1:0];
      mul_b = u_ff;
      case (state_ff)
         ST_X_MUL: begin
            mul_a = xmag_ff;
            mul_b = LN3_Q;
         end
         ST_MUL_HI: begin
            mul_a = U_W'(mag_ff[MAG_W-1:U_W]);
         end
         default: begin
            mul_a = mag_ff[U_W-1:0];
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // round half up on the magnitude, then clamp at the term limit
   assign rnd_sum  = {1'b0, prod_ff} + RND_HALF;
   assign rnd_full = rnd_sum >> FRAC_BITS;
   assign term_p   = (rnd_full > (PROD_W + 1)'(TERM_LIMIT)) ? TERM_LIMIT
                                                            : rnd_full[MAG_W-1:0];

   // two restoring division steps by the term index per cycle
   always_comb begin
      dvs    = {1'b0, k_ff};
      r1_raw = {rem_ff, div_ff[DIV_W-1]};
      q1     = (r1_raw >= dvs);
      r1     = q1 ? (r1_raw - dvs) : r1_raw;
      r2_raw = {r1[K_W-1:0], div_ff[DIV_W-2]};
      q2     = (r2_raw >= dvs);
      r2     = q2 ? (r2_raw - dvs) : r2_raw;
      div_step = {div_ff[DIV_W-3:0], q1, q2};
   end

   // tally of the tolerance sum, clamped to the response field
   assign used_x   = USED_XW'(used_ff);
   assign used_sat = (used_x > USED_XW'(USED_CAP)) ? USED_OUT_W'(USED_CAP)
                                                   : used_x[USED_OUT_W-1:0];

   always_comb begin
      state_in     = state_ff;
      tc_in        = tc_ff;
      tol_in       = tol_ff;
      xmag_in      = xmag_ff;
      neg_u_in     = neg_u_ff;
      u_in         = u_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      k_in         = k_ff;
      prod_in      = prod_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      dcnt_in      = dcnt_ff;
      fixed_in     = fixed_ff;
      tsum_in      = tsum_ff;
      used_in      = used_ff;
      active_in    = active_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_fixed_in = rsp_fixed_ff;
      rsp_tsum_in  = rsp_tsum_ff;
      rsp_used_in  = rsp_used_ff;
      rsp_limit_in = rsp_limit_ff;

      // the user must make register writes only while idle; the block does not enforce it
      if (csr_write) begin
         case (csr_index)
            CSR_TERM_COUNT: tc_in  = csr_data[CNT_W-1:0];
            CSR_TOLERANCE:  tol_in = csr_data[TOL_W-1:0];
            default: begin
               tc_in = tc_ff;
            end
         endcase
      end

      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               neg_u_in = req_x_value[X_W-1];
               xmag_in  = req_x_value[X_W-1] ? (~req_x_value + X_W'(1)) : req_x_value;
               state_in = ST_X_MUL;
            end
         end
         ST_X_MUL: begin
            prod_in  = PROD_W'(mul_p);
            state_in = ST_X_RND;
         end
         ST_X_RND: begin
            // u = round(ln3 * |x|), always within 32 bits
            u_in      = rnd_full[U_W-1:0];
            mag_in    = ONE_Q;
            neg_in    = 1'b0;
            k_in      = '0;
            fixed_in  = '0;
            tsum_in   = '0;
            used_in   = '0;
            active_in = (ONE_Q > MAG_W'(tol_ff));
            state_in  = ST_ACC;
         end
         ST_ACC: begin
            if (k_ff <= K_W'(tc_ff)) begin
               fixed_in = sat_add(fixed_ff, mag_ff, neg_ff);
            end
            if (active_ff && ((K_W + 1)'(k_ff) < (K_W + 1)'(MAX_TERMS))) begin
               tsum_in = sat_add(tsum_ff, mag_ff, neg_ff);
               used_in = used_ff + USED_W'(1);
               if (mag_ff <= MAG_W'(tol_ff)) begin
                  active_in = 1'b0;
               end
            end
            if (k_ff == K_W'(LAST)) begin
               state_in = ST_FIN;
            end else begin
               k_in     = k_ff + K_W'(1);
               state_in = ST_MUL_LO;
            end
         end
         ST_MUL_LO: begin
            prod_in  = PROD_W'(mul_p);
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            prod_in  = prod_ff + PROD_W'({mul_p, {U_W{1'b0}}});
            state_in = ST_RND;
         end
         ST_RND: begin
            div_in   = DIV_W'(term_p);
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            // bias by k/2 so the quotient rounds half up
            div_in   = div_ff + DIV_W'(k_ff >> 1);
            rem_in   = '0;
            dcnt_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            div_in  = div_step;
            rem_in  = r2[K_W-1:0];
            dcnt_in = dcnt_ff + DCNT_W'(1);
            if (dcnt_ff == DCNT_W'(DIV_STEPS - 1)) begin
               mag_in   = div_step[MAG_W-1:0];
               neg_in   = neg_ff ^ neg_u_ff;
               state_in = ST_ACC;
            end
         end
         ST_FIN: begin
            // wait here only if the previous response is still stalled
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_fixed_in = fixed_ff;
               rsp_tsum_in  = tsum_ff;
               rsp_used_in  = used_sat;
               rsp_limit_in = active_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tc_ff        <= '0;
         tol_ff       <= TOL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tc_ff        <= tc_in;
         tol_ff       <= tol_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      xmag_ff      <= xmag_in;
      neg_u_ff     <= neg_u_in;
      u_ff         <= u_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      k_ff         <= k_in;
      prod_ff      <= prod_in;
      div_ff       <= div_in;
      rem_ff       <= rem_in;
      dcnt_ff      <= dcnt_in;
      fixed_ff     <= fixed_in;
      tsum_ff      <= tsum_in;
      used_ff      <= used_in;
      active_ff    <= active_in;
      rsp_fixed_ff <= rsp_fixed_in;
      rsp_tsum_ff  <= rsp_tsum_in;
      rsp_used_ff  <= rsp_used_in;
      rsp_limit_ff <= rsp_limit_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_sum_fixed_terms  = rsp_fixed_ff;
   assign rsp_sum_to_tolerance = rsp_tsum_ff;
   assign rsp_terms_used       = rsp_used_ff;
   assign rsp_limit_hit        = rsp_limit_ff;

   // an accepted request starts the argument multiply next cycle
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_X_MUL))
      else $error("request accepted but sequencer did not start");

   // divider never runs past its step count
   a_div_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (dcnt_ff < DCNT_W'(DIV_STEPS)))
      else $error("divider step count overrun");

   // a term never exceeds the magnitude limit
   a_term_lim: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC) |-> (mag_ff <= TERM_LIMIT))
      else $error("term magnitude above limit");

   // hitting the limit means every allowed term was added
   a_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_limit_ff) |-> (rsp_used_ff == USED_OUT_W'(LIM_OUT)))
      else $error("limit flag with short term tally");

   // no terms added means an empty tolerance sum
   a_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_used_ff == '0)) |-> ((rsp_tsum_ff == '0) && !rsp_limit_ff))
      else $error("empty tolerance sum not zero");

endmodule

[tb/power_of_three_series_test.sv]
// ----------------------------------------------------------------------------
// power_of_three_series_test
// Self-checking bench for the power-of-three series block. A queue-fed
// driver sends arguments and a clocked monitor checks each response,
// field by field, against sums worked out here from the argument and the
// current register settings. Register settings change between phases, only
// once every response has come back. Both channels idle at random.
// ----------------------------------------------------------------------------
module power_of_three_series_test;
   import p3s_pkg::*;

   // series arithmetic, Q.28 throughout
   localparam int              Q_FRAC     = 28;
   localparam int              SERIES_MAX = 64;
   localparam int              LAST_INDEX = 63;
   localparam longint unsigned LN3_Q41_C  = 64'd2415873971616;
   localparam longint unsigned LN3_FIX    = ((LN3_Q41_C >> (40 - Q_FRAC)) + 64'd1) >> 1;
   localparam longint unsigned TERM_CAP   = 64'd1 << 60;
   localparam longint          SUM_TOP    = (longint'(1) << 47) - 1;
   localparam longint          SUM_BOTTOM = -SUM_TOP - 1;
   localparam longint unsigned ONE_FIX    = 64'd1 << Q_FRAC;

   // run control
   localparam int STALL_LIMIT = 20000;
   localparam int TAIL_CYCLES = 40;
   localparam int REPORT_CAP  = 40;
   localparam int PHASE_ITEMS = 38;

   typedef struct packed {
      logic [X_W-1:0]          x;
      logic signed [SUM_W-1:0] fixed_sum;
      logic signed [SUM_W-1:0] tol_sum;
      logic [USED_OUT_W-1:0]   used;
      logic                    limit;
   } power_sums_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_data = '0;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic signed [X_W-1:0]   req_x_value = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [SUM_W-1:0] rsp_sum_fixed_terms;
   logic signed [SUM_W-1:0] rsp_sum_to_tolerance;
   logic [USED_OUT_W-1:0]   rsp_terms_used;
   logic                    rsp_limit_hit;

   // shadow copy of the two registers, as last written
   logic [5:0]              cfg_terms = 6'd0;
   logic [CSR_DATA_W-1:0]   cfg_tol = TOL_RESET;

   logic [X_W-1:0]          queued_arguments[$];
   power_sums_type          awaited_sums[$];

   int                      error_count = 0;
   int                      quiet_cycles = 0;
   int                      send_idle_pct = 0;
   int                      recv_idle_pct = 0;

   power_of_three_series dut (
      .clock                (clock),
      .reset                (reset),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_x_value          (req_x_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_sum_fixed_terms  (rsp_sum_fixed_terms),
      .rsp_sum_to_tolerance (rsp_sum_to_tolerance),
      .rsp_terms_used       (rsp_terms_used),
      .rsp_limit_hit        (rsp_limit_hit)
   );

   always #10 clock = ~clock;

   // round(a*b / 2^28), half away from zero on magnitudes, capped at 2^60
   function automatic longint unsigned scaled_product(longint unsigned a,
                                                      longint unsigned b);
      logic [127:0] wide;
      wide = (128'(a) * 128'(b) + (128'd1 << (Q_FRAC - 1))) >> Q_FRAC;
      return (wide > 128'(TERM_CAP)) ? TERM_CAP : wide[63:0];
   endfunction

   // running sum plus or minus a term, clamped to the signed 48-bit range
   function automatic longint clamped_sum(longint acc, longint unsigned mag, logic neg);
      longint s;
      s = neg ? acc - longint'(mag) : acc + longint'(mag);
      if (s > SUM_TOP) begin
         return SUM_TOP;
      end
      if (s < SUM_BOTTOM) begin
         return SUM_BOTTOM;
      end
      return s;
   endfunction

   // both series sums of 3^x for one argument under the current settings
   function automatic power_sums_type predict_power_sums(logic [X_W-1:0] x);
      power_sums_type  r;
      logic            neg_x;
      logic [X_W-1:0]  x_mag;
      longint unsigned u_mag;
      longint unsigned mag;
      longint unsigned prod;
      logic            neg;
      logic            running;
      longint          fixed_acc;
      longint          tol_acc;
      int              used;
      neg_x     = x[X_W-1];
      x_mag     = neg_x ? -x : x;
      u_mag     = scaled_product(64'(x_mag), LN3_FIX);
      mag       = ONE_FIX;
      neg       = 1'b0;
      fixed_acc = 0;
      tol_acc   = 0;
      used      = 0;
      // a tolerance of 1.0 or more is met by the first term before it is added
      running   = mag > 64'(cfg_tol);
      for (int k = 0; k <= LAST_INDEX; k++) begin
         if (k > 0) begin
            prod = scaled_product(mag, u_mag);
            mag  = (prod + 64'(k / 2)) / 64'(k);
            neg  = neg ^ neg_x;
         end
         if (k <= int'(cfg_terms)) begin
            fixed_acc = clamped_sum(fixed_acc, mag, neg);
         end
         if (running && k < SERIES_MAX) begin
            tol_acc = clamped_sum(tol_acc, mag, neg);
            used++;
            if (mag <= 64'(cfg_tol)) begin
               running = 1'b0;
            end
         end
      end
      r.x         = x;
      r.fixed_sum = fixed_acc[SUM_W-1:0];
      r.tol_sum   = tol_acc[SUM_W-1:0];
      r.used      = (used > USED_CAP) ? USED_OUT_W'(USED_CAP) : USED_OUT_W'(used);
      // still running after the last allowed term means the cap was reached
      r.limit     = running;
      return r;
   endfunction

   task automatic report_mismatch(string what);
      if (error_count < REPORT_CAP) begin
         $display("mismatch: %s", what);
      end
      error_count++;
   endtask

   // one register write, only ever issued while the block is idle
   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      if (idx == CSR_TERM_COUNT) begin
         cfg_terms = value[5:0];
      end else begin
         cfg_tol = value;
      end
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // sender holds off until every response of the phase has come back
   task automatic drain_all();
      while (queued_arguments.size() != 0 || req_valid || awaited_sums.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // mostly full-range arguments, with a share near the interesting region
   // of a few units either side of zero and exact integer exponents
   task automatic queue_random_arguments(int count);
      logic [X_W-1:0] x;
      logic [X_W-1:0] m;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(3))
            0, 1: begin
               x = $urandom;
            end
            2: begin
               m = $urandom_range(0, 32'h4000_0000);
               x = $urandom_range(1) ? -m : m;
            end
            default: begin
               x = ($urandom_range(0, 15) - 8) << Q_FRAC;
            end
         endcase
         queued_arguments.push_back(x);
      end
   endtask

   // driver: a new transaction is offered once the current one is taken
   always @(posedge clock) begin
      logic offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            awaited_sums.push_back(predict_power_sums(req_x_value));
         end
         offer = queued_arguments.size() != 0 && $urandom_range(99) >= send_idle_pct;
         if (offer) begin
            req_x_value <= queued_arguments.pop_front();
         end
         req_valid <= offer;
      end
   end

   // monitor: each accepted response is checked against the oldest prediction
   always @(posedge clock) begin
      power_sums_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_sums.size() == 0) begin
               report_mismatch("response transaction with nothing outstanding");
            end else begin
               want = awaited_sums.pop_front();
               if (rsp_sum_fixed_terms !== want.fixed_sum) begin
                  report_mismatch($sformatf("sum_fixed_terms x=%h got %0d want %0d",
                     want.x, rsp_sum_fixed_terms, want.fixed_sum));
               end
               if (rsp_sum_to_tolerance !== want.tol_sum) begin
                  report_mismatch($sformatf("sum_to_tolerance x=%h got %0d want %0d",
                     want.x, rsp_sum_to_tolerance, want.tol_sum));
               end
               if (rsp_terms_used !== want.used) begin
                  report_mismatch($sformatf("terms_used x=%h got %0d want %0d",
                     want.x, rsp_terms_used, want.used));
               end
               if (rsp_limit_hit !== want.limit) begin
                  report_mismatch($sformatf("limit_hit x=%h got %b want %b",
                     want.x, rsp_limit_hit, want.limit));
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // watchdog: too long without any transaction or register write
   always @(posedge clock) begin
      if (reset || csr_write || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // sender idles often, receiver stalls most of the time
      send_idle_pct = 34;
      recv_idle_pct = 75;

      // reset settings: argument extremes, zero, one and integer exponents
      queued_arguments.push_back(32'h0000_0000);
      queued_arguments.push_back(32'h0000_0001);
      queued_arguments.push_back(32'hFFFF_FFFF);
      queued_arguments.push_back(32'h7FFF_FFFF);
      queued_arguments.push_back(32'h8000_0000);
      queued_arguments.push_back(32'h1000_0000);
      queued_arguments.push_back(32'hF000_0000);
      queued_arguments.push_back(32'h2000_0000);
      queued_arguments.push_back(32'hD000_0000);
      drain_all();

      // longest fixed sum and a zero tolerance, so only a zero term stops it
      write_register(CSR_TERM_COUNT, 29'd63);
      write_register(CSR_TOLERANCE, 29'd0);
      queued_arguments.push_back(32'h0000_0000);
      queued_arguments.push_back(32'h7FFF_FFFF);
      queued_arguments.push_back(32'h8000_0000);
      queued_arguments.push_back(32'h1000_0000);
      queued_arguments.push_back(32'hF000_0000);
      queued_arguments.push_back(32'h0000_0001);
      queued_arguments.push_back(32'h5000_0000);
      queued_arguments.push_back(32'hB000_0000);
      queued_arguments.push_back(32'h1234_5678);
      queued_arguments.push_back(32'hEDCB_A987);
      drain_all();

      // tolerance exactly 1.0: nothing goes into the tolerance sum; the term
      // count write carries junk above its six bits
      write_register(CSR_TERM_COUNT, CSR_DATA_W'($urandom));
      write_register(CSR_TOLERANCE, 29'h1000_0000);
      queue_random_arguments(PHASE_ITEMS);
      drain_all();

      // roles swapped: receiver mostly ready, sender mostly idle
      send_idle_pct = 75;
      recv_idle_pct = 34;

      // tolerance at the top of its field, two-term fixed sum
      write_register(CSR_TERM_COUNT, 29'd1);
      write_register(CSR_TOLERANCE, {CSR_DATA_W{1'b1}});
      queue_random_arguments(PHASE_ITEMS);
      drain_all();

      // smallest non-zero tolerance
      write_register(CSR_TERM_COUNT, 29'd63);
      write_register(CSR_TOLERANCE, 29'd1);
      queue_random_arguments(PHASE_ITEMS);
      drain_all();

      write_register(CSR_TERM_COUNT, CSR_DATA_W'($urandom_range(0, 63)));
      write_register(CSR_TOLERANCE, CSR_DATA_W'($urandom_range(0, 32'h1000_0000)));
      queue_random_arguments(PHASE_ITEMS);
      drain_all();

      // back-to-back stretch with no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;

      write_register(CSR_TERM_COUNT, 29'd0);
      write_register(CSR_TOLERANCE, TOL_RESET);
      queue_random_arguments(PHASE_ITEMS);
      drain_all();

      write_register(CSR_TERM_COUNT, CSR_DATA_W'($urandom_range(0, 63)));
      write_register(CSR_TOLERANCE, CSR_DATA_W'($urandom));
      queue_random_arguments(PHASE_ITEMS);
      drain_all();

      // let any stray response show up before the verdict
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && awaited_sums.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
